// ===== sv/teq_pkg.sv =====
// ----------------------------------------------------------------------------
// teq_pkg: shared types and constants of the timed event queue
// Beat layouts, queue entry, cell command and result codes.
// ----------------------------------------------------------------------------
`default_nettype none

package teq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TAG_BITS    = 16;
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] OP_ADD     = 2'd0;
   localparam logic [1:0] OP_ADVANCE = 2'd1;
   localparam logic [1:0] OP_REMOVE  = 2'd2;
   localparam logic [1:0] OP_LIST    = 2'd3;

   localparam logic [2:0] KIND_FIRED  = 3'd0;
   localparam logic [2:0] KIND_LISTED = 3'd1;
   localparam logic [2:0] KIND_DONE   = 3'd2;
   localparam logic [2:0] KIND_PAST   = 3'd3;
   localparam logic [2:0] KIND_FULL   = 3'd4;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] event_time;
      logic [15:0] event_tag;
      logic [31:0] time_step;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] out_time;
      logic [15:0] out_tag;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic                valid;
      logic [31:0]         ev_time;
      logic [TAG_BITS-1:0] tag;
   } entry_type;

   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_INSERT,
      CMD_SHIFT,
      CMD_REMOVE,
      CMD_ROTATE
   } cmd_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [31:0]         key_time;
      logic [TAG_BITS-1:0] new_tag;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== sv/teq_cell.sv =====
// ----------------------------------------------------------------------------
// teq_cell: one slot of the sorted event chain
// Holds one entry; inserts, shifts left, compacts or rotates with neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module teq_cell (
   input  wire                    clock,
   input  wire                    reset,
   input  teq_pkg::cell_ctrl_type ctrl,
   input  teq_pkg::entry_type     left_entry,
   input  wire                    left_le,
   input  teq_pkg::entry_type     right_entry,
   output teq_pkg::entry_type     entry_out,
   output logic                   le,
   output logic                   match
);

   teq_pkg::entry_type entry_ff;
   teq_pkg::entry_type entry_in;

   assign le        = entry_ff.valid && (entry_ff.ev_time <= ctrl.key_time);
   assign match     = entry_ff.valid && (entry_ff.ev_time == ctrl.key_time);
   assign entry_out = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      unique case (ctrl.cmd) inside
         teq_pkg::CMD_HOLD: begin
         end
         teq_pkg::CMD_INSERT: begin
            if (!le) begin
               if (left_le) begin
                  entry_in = '{valid: 1'b1, ev_time: ctrl.key_time, tag: ctrl.new_tag};
               end else begin
                  entry_in = left_entry;
               end
            end
         end
         teq_pkg::CMD_SHIFT, teq_pkg::CMD_ROTATE: begin
            entry_in = right_entry;
         end
         teq_pkg::CMD_REMOVE: begin
            // matches are contiguous: everything from the first match on moves
            if (!entry_ff.valid || (entry_ff.ev_time >= ctrl.key_time)) begin
               entry_in = right_entry;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.ev_time <= entry_in.ev_time;
      entry_ff.tag     <= entry_in.tag;
   end

endmodule

`default_nettype wire

// ===== sv/timed_event_queue.sv =====
// ----------------------------------------------------------------------------
// timed_event_queue: time-sorted event queue with a current time
// Add, advance (fire due events), remove and list by time over a cell chain.
// ----------------------------------------------------------------------------
//  channel  dir  ports                          beat
//  req      in   req_valid req_stall req_data   one operation
//  rsp      out  rsp_valid rsp_stall rsp_data   one event or status, last marks end
//
//  Add: insert, then status. Advance: fire due events, then status. Remove: drop
//  matches, then status. List: one chain rotation per cycle while output is free.
//  Each output beat needs the single output register free; rsp_stall holds
//  the sequencer in place. req_stall is high while an operation is in work.
//  Reset empties the queue and clears the current time.
`default_nettype none

module timed_event_queue (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  teq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output teq_pkg::rsp_type rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_REMOVE,
      ST_LIST,
      ST_STATUS
   } state_type;

   localparam teq_pkg::entry_type EMPTY_ENTRY = '{valid: 1'b0, ev_time: '0, tag: '0};

   state_type                     state_ff, state_in;
   logic [31:0]                   now_ff, now_in;
   logic [31:0]                   key_ff, key_in;
   logic [2:0]                    status_ff, status_in;
   logic [teq_pkg::CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   teq_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   teq_pkg::entry_type            cell_q [teq_pkg::QUEUE_DEPTH];
   logic [teq_pkg::QUEUE_DEPTH-1:0] le_vec;
   logic [teq_pkg::QUEUE_DEPTH-1:0] match_vec;
   logic [teq_pkg::QUEUE_DEPTH-1:0] valid_vec;
   teq_pkg::cell_ctrl_type        ctrl;
   teq_pkg::cmd_type              cmd;
   teq_pkg::entry_type            tail_in;

   logic [32:0]                   now_sum;
   logic [31:0]                   now_sat;
   logic                          head_due;
   logic                          out_free;
   logic                          full;
   logic                          any_match;
   logic                          emit;
   teq_pkg::rsp_type              emit_data;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign ctrl    = '{cmd:      cmd,
                      key_time: (state_ff == ST_IDLE) ? req_data.event_time : key_ff,
                      new_tag:  teq_pkg::TAG_BITS'(req_data.event_tag)};
   assign tail_in = (cmd == teq_pkg::CMD_ROTATE) ? cell_q[0] : EMPTY_ENTRY;

   genvar gi;
   generate
      for (gi = 0; gi < teq_pkg::QUEUE_DEPTH; gi++) begin : g_cell
         teq_pkg::entry_type left_e;
         teq_pkg::entry_type right_e;
         logic               left_le_w;
         if (gi == 0) begin : g_head
            assign left_e    = EMPTY_ENTRY;
            assign left_le_w = 1'b1;
         end else begin : g_mid_l
            assign left_e    = cell_q[gi-1];
            assign left_le_w = le_vec[gi-1];
         end
         if (gi == teq_pkg::QUEUE_DEPTH - 1) begin : g_tail
            assign right_e = tail_in;
         end else begin : g_mid_r
            assign right_e = cell_q[gi+1];
         end
         teq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .left_entry  (left_e),
            .left_le     (left_le_w),
            .right_entry (right_e),
            .entry_out   (cell_q[gi]),
            .le          (le_vec[gi]),
            .match       (match_vec[gi])
         );
         assign valid_vec[gi] = cell_q[gi].valid;
      end
   endgenerate

   assign now_sum   = {1'b0, now_ff} + {1'b0, req_data.time_step};
   assign now_sat   = now_sum[32] ? 32'hFFFF_FFFF : now_sum[31:0];
   assign head_due  = cell_q[0].valid && (cell_q[0].ev_time <= now_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign full      = cell_q[teq_pkg::QUEUE_DEPTH-1].valid;
   assign any_match = |match_vec;

   always_comb begin
      state_in  = state_ff;
      now_in    = now_ff;
      key_in    = key_ff;
      status_in = status_ff;
      cnt_in    = cnt_ff;
      cmd       = teq_pkg::CMD_HOLD;
      emit      = 1'b0;
      emit_data = '{kind: teq_pkg::KIND_DONE, out_time: now_ff, out_tag: '0, last: 1'b0};
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               key_in    = req_data.event_time;
               status_in = teq_pkg::KIND_DONE;
               cnt_in    = '0;
               unique case (req_data.opcode)
                  teq_pkg::OP_ADD: begin
                     state_in = ST_STATUS;
                     if (req_data.event_time <= now_ff) begin
                        status_in = teq_pkg::KIND_PAST;
                     end else if (full) begin
                        status_in = teq_pkg::KIND_FULL;
                     end else begin
                        cmd = teq_pkg::CMD_INSERT;
                     end
                  end
                  teq_pkg::OP_ADVANCE: begin
                     now_in   = now_sat;
                     state_in = ST_POP;
                  end
                  teq_pkg::OP_REMOVE: begin
                     state_in = ST_REMOVE;
                  end
                  teq_pkg::OP_LIST: begin
                     state_in = ST_LIST;
                  end
                  default: begin
                     state_in = ST_STATUS;
                  end
               endcase
            end
         end
         ST_POP: begin
            if (head_due) begin
               if (out_free) begin
                  emit      = 1'b1;
                  emit_data = '{kind: teq_pkg::KIND_FIRED, out_time: cell_q[0].ev_time,
                                out_tag: 16'(cell_q[0].tag), last: 1'b0};
                  cmd       = teq_pkg::CMD_SHIFT;
               end
            end else begin
               state_in = ST_STATUS;
            end
         end
         ST_REMOVE: begin
            if (any_match) begin
               cmd = teq_pkg::CMD_REMOVE;
            end else begin
               state_in = ST_STATUS;
            end
         end
         ST_LIST: begin
            if (out_free) begin
               cmd = teq_pkg::CMD_ROTATE;
               if (match_vec[0]) begin
                  emit      = 1'b1;
                  emit_data = '{kind: teq_pkg::KIND_LISTED, out_time: cell_q[0].ev_time,
                                out_tag: 16'(cell_q[0].tag), last: 1'b0};
               end
               cnt_in = teq_pkg::CNT_BITS'(cnt_ff + 1'b1);
               if (cnt_ff == teq_pkg::CNT_BITS'(teq_pkg::QUEUE_DEPTH - 1)) begin
                  state_in = ST_STATUS;
               end
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_data = '{kind: status_ff, out_time: now_ff, out_tag: '0, last: 1'b1};
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = out_free ? emit : rsp_valid_ff;
      rsp_data_in  = (out_free && emit) ? emit_data : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         now_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff      <= key_in;
      status_ff   <= status_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LIST) |->
         $onehot({1'b0, valid_vec} + (teq_pkg::QUEUE_DEPTH + 1)'(1)))
      else $error("valid slots do not form a prefix");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd == teq_pkg::CMD_INSERT) |=>
         ($countones(valid_vec) == $past($countones(valid_vec)) + 1))
      else $error("insert did not add exactly one entry");

   a_drop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (cmd == teq_pkg::CMD_SHIFT || cmd == teq_pkg::CMD_REMOVE) |=>
         ($countones(valid_vec) == $past($countones(valid_vec)) - 1))
      else $error("pop or remove did not drop exactly one entry");

   a_rotate_keeps: assert property (@(posedge clock) disable iff (reset)
      (cmd == teq_pkg::CMD_ROTATE) |=>
         ($countones(valid_vec) == $past($countones(valid_vec))))
      else $error("rotation changed occupancy");

   a_now_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (now_ff >= $past(now_ff)))
      else $error("current time moved backward");

endmodule

`default_nettype wire
